### sv/atapi_packet_command_unit_assert.svh
// Assertion helpers for the packet command unit.
// Each macro expects clk and rst_n in scope.
`ifndef ATAPI_PACKET_COMMAND_UNIT_ASSERT_SVH
`define ATAPI_PACKET_COMMAND_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define APCU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define APCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/apcu_pkg.sv
package apcu_pkg;

    // Input command beat
    typedef struct packed {
        logic [7:0]  func;
        logic [4:0]  cdb_length;
        logic [31:0] block_address;
        logic [15:0] block_count;
        logic        read_ok;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [26:0] xfer_bytes;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        read_request;
        logic [31:0] read_address;
        logic [15:0] read_sectors;
        logic        last;
    } rsp_t;

    // Configuration register file
    typedef struct packed {
        logic        media_present;
        logic [31:0] sector_count;
        logic [63:0] vendor_text;
        logic [63:0] product_text_upper;
        logic [63:0] product_text_lower;
        logic [31:0] revision_text;
    } cfg_t;

    typedef struct packed {
        logic [3:0] key;
        logic [7:0] code;
        logic [7:0] qual;
    } sense_t;

    typedef enum logic [2:0] {
        JOB_STATUS,
        JOB_INQUIRY,
        JOB_SENSE,
        JOB_CAPACITY,
        JOB_MODE
    } job_kind_t;

    // Classified command handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [1:0]  status;
        logic [26:0] tlen;
        logic        read_request;
        logic [31:0] read_address;
        logic [15:0] read_sectors;
        sense_t      sense;
    } job_t;

    // Register indexes
    localparam logic [2:0] CFG_MEDIA_PRESENT = 3'd0;
    localparam logic [2:0] CFG_SECTOR_COUNT  = 3'd1;
    localparam logic [2:0] CFG_VENDOR        = 3'd2;
    localparam logic [2:0] CFG_PRODUCT_UPPER = 3'd3;
    localparam logic [2:0] CFG_PRODUCT_LOWER = 3'd4;
    localparam logic [2:0] CFG_REVISION      = 3'd5;

    // Status codes
    localparam logic [1:0] STATUS_GOOD  = 2'd0;
    localparam logic [1:0] STATUS_CHECK = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Opcodes
    localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
    localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
    localparam logic [7:0] OP_INQUIRY         = 8'h12;
    localparam logic [7:0] OP_MODE_SENSE6     = 8'h1A;
    localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
    localparam logic [7:0] OP_READ10          = 8'h28;

    // Sense keys and additional codes
    localparam logic [3:0] SK_NONE            = 4'h0;
    localparam logic [3:0] SK_NOT_READY       = 4'h2;
    localparam logic [3:0] SK_ILLEGAL_REQUEST = 4'h5;
    localparam logic [7:0] ASC_NONE           = 8'h00;
    localparam logic [7:0] ASC_NO_MEDIUM      = 8'h3A;
    localparam logic [7:0] ASC_LBA_RANGE      = 8'h21;
    localparam logic [7:0] ASC_BAD_OPCODE     = 8'h20;
    localparam logic [7:0] ASCQ_NONE          = 8'h00;

    // Response lengths in bytes
    localparam logic [26:0] INQUIRY_BYTES  = 27'd36;
    localparam logic [26:0] SENSE_BYTES    = 27'd18;
    localparam logic [26:0] CAPACITY_BYTES = 27'd8;
    localparam logic [26:0] MODE_BYTES     = 27'd8;

    // Fixed response bytes
    localparam logic [7:0] INQ_DEVICE_TYPE = 8'h05;
    localparam logic [7:0] INQ_REMOVABLE   = 8'h80;
    localparam logic [7:0] INQ_FORMAT      = 8'h21;
    localparam logic [7:0] INQ_ADD_LENGTH  = 8'd31;
    localparam logic [7:0] SENSE_FIXED     = 8'h70;
    localparam logic [7:0] SENSE_ADD_LEN   = 8'd10;
    localparam logic [7:0] MODE_DATA_LEN   = 8'd6;

    localparam logic [15:0] READ_ZERO_COUNT = 16'd65535;
    localparam logic [26:0] TLEN_MAX        = 27'h7FF_FFFF;

    localparam int JOB_QUEUE_DEPTH = 2;

endpackage

### sv/atapi_packet_command_unit.sv
// A command is written into the job queue, then into the sequencer's job register, and each
// result beat is registered in the output slot. Throughput: one result beat per cycle while
// the consumer pops; the byte sequencer gives 1 beat for status-only, 8, 18, or 36 for inquiry.
// A two-entry job queue lets new commands be taken while a response streams out.
// Reset (rst_n low, asynchronous): queue, sequencer, sense data and config cleared.
`include "atapi_packet_command_unit_assert.svh"

module atapi_packet_command_unit
    import apcu_pkg::*;
#(
    parameter int SECTOR_BYTES = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  cmd_t        cmd,
    output logic        empty,
    input  logic        pop,
    output rsp_t        rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_t cfg_reg;
    job_t front_job;
    job_t head_job;
    logic accept;
    logic head_valid;
    logic head_take;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MEDIA_PRESENT: cfg_reg.media_present      <= cfg_data[0];
                CFG_SECTOR_COUNT:  cfg_reg.sector_count       <= cfg_data[31:0];
                CFG_VENDOR:        cfg_reg.vendor_text        <= cfg_data;
                CFG_PRODUCT_UPPER: cfg_reg.product_text_upper <= cfg_data;
                CFG_PRODUCT_LOWER: cfg_reg.product_text_lower <= cfg_data;
                CFG_REVISION:      cfg_reg.revision_text      <= cfg_data[31:0];
                default:           cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    apcu_front #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd           (cmd),
        .media_present (cfg_reg.media_present),
        .job           (front_job)
    );

    apcu_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_job   (front_job),
        .full     (full),
        .rd_en    (head_take),
        .rd_valid (head_valid),
        .rd_job   (head_job)
    );

    apcu_back #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (head_valid),
        .job       (head_job),
        .job_take  (head_take),
        .pop       (pop),
        .empty     (empty),
        .rsp       (rsp)
    );

    // Checks on the result stream
    `APCU_ASSERT_IMP(a_status_only_last, !empty && !rsp.data_valid, rsp.last, "status-only beat")
    `APCU_ASSERT_IMP(a_check_no_length, !empty && rsp.status != STATUS_GOOD, rsp.xfer_bytes == '0, "fail len")
    `APCU_ASSERT_IMP(a_data_good, !empty && rsp.data_valid, rsp.status == STATUS_GOOD && !rsp.read_request, "bad data")
    `APCU_ASSERT_IMP(a_read_sectors, !empty && rsp.read_request, rsp.read_sectors != 16'd0, "zero sectors")

endmodule

### sv/apcu_front.sv
module apcu_front
    import apcu_pkg::*;
#(
    parameter int SECTOR_BYTES = 2048
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  cmd_t cmd,
    input  logic media_present,
    output job_t job
);

    sense_t sense_reg;
    sense_t sense_next;

    logic [15:0] sectors;
    logic [31:0] product;
    logic [26:0] read_tlen;

    // Read length: zero count means the maximum, bytes saturate at the field width
    always_comb
    begin
        sectors   = (cmd.block_count == 16'd0) ? READ_ZERO_COUNT : cmd.block_count;
        product   = 32'(sectors) * 32'(SECTOR_BYTES);
        read_tlen = (product > 32'(TLEN_MAX)) ? TLEN_MAX : product[26:0];
    end

    // Classify the command and work out the new sense
    always_comb
    begin
        job.kind         = JOB_STATUS;
        job.status       = STATUS_GOOD;
        job.tlen         = '0;
        job.read_request = 1'b0;
        job.read_address = '0;
        job.read_sectors = '0;
        job.sense        = sense_reg;
        sense_next       = sense_reg;
        if (cmd.cdb_length == 5'd0)
        begin
            job.status = STATUS_EMPTY;
        end
        else
        begin
            case (cmd.func)
                OP_TEST_UNIT_READY:
                begin
                    if (media_present)
                    begin
                        sense_next = '{SK_NONE, ASC_NONE, ASCQ_NONE};
                    end
                    else
                    begin
                        sense_next = '{SK_NOT_READY, ASC_NO_MEDIUM, ASCQ_NONE};
                        job.status = STATUS_CHECK;
                    end
                end
                OP_INQUIRY:
                begin
                    job.kind   = JOB_INQUIRY;
                    job.tlen   = INQUIRY_BYTES;
                    sense_next = '{SK_NONE, ASC_NONE, ASCQ_NONE};
                end
                OP_REQUEST_SENSE:
                begin
                    job.kind = JOB_SENSE;
                    job.tlen = SENSE_BYTES;
                end
                OP_READ_CAPACITY:
                begin
                    if (media_present)
                    begin
                        job.kind   = JOB_CAPACITY;
                        job.tlen   = CAPACITY_BYTES;
                        sense_next = '{SK_NONE, ASC_NONE, ASCQ_NONE};
                    end
                    else
                    begin
                        sense_next = '{SK_NOT_READY, ASC_NO_MEDIUM, ASCQ_NONE};
                        job.status = STATUS_CHECK;
                    end
                end
                OP_READ10:
                begin
                    job.read_request = 1'b1;
                    job.read_address = cmd.block_address;
                    job.read_sectors = sectors;
                    if (cmd.read_ok)
                    begin
                        job.tlen   = read_tlen;
                        sense_next = '{SK_NONE, ASC_NONE, ASCQ_NONE};
                    end
                    else
                    begin
                        job.status = STATUS_CHECK;
                        sense_next = '{SK_ILLEGAL_REQUEST, ASC_LBA_RANGE, ASCQ_NONE};
                    end
                end
                OP_MODE_SENSE6:
                begin
                    job.kind   = JOB_MODE;
                    job.tlen   = MODE_BYTES;
                    sense_next = '{SK_NONE, ASC_NONE, ASCQ_NONE};
                end
                default:
                begin
                    job.status = STATUS_CHECK;
                    sense_next = '{SK_ILLEGAL_REQUEST, ASC_BAD_OPCODE, ASCQ_NONE};
                end
            endcase
        end
    end

    // Sense data, updated in command order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sense_reg <= '0;
        end
        else if (accept)
        begin
            sense_reg <= sense_next;
        end
    end

endmodule

### sv/apcu_job_queue.sv
module apcu_job_queue
    import apcu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output job_t rd_job
);

    localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

    job_t             entry_reg [JOB_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(JOB_QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### sv/apcu_back.sv
module apcu_back
    import apcu_pkg::*;
#(
    parameter int SECTOR_BYTES = 2048
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic job_valid,
    input  job_t job,
    output logic job_take,
    input  logic pop,
    output logic empty,
    output rsp_t rsp
);

    job_t        job_reg;
    logic        busy_reg, busy_next;
    logic [5:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_reg;

    logic        advance;
    logic        final_beat;
    logic [5:0]  last_idx;
    logic [7:0]  data;
    logic [63:0] text;
    logic [5:0]  text_sh;
    logic [31:0] word;
    logic [31:0] last_lba;
    logic [63:0] text_byte;
    logic [31:0] word_byte;
    rsp_t        beat;

    assign empty    = !out_valid_reg;
    assign rsp      = out_reg;
    assign last_idx = job_reg.tlen[5:0] - 6'd1;
    assign last_lba = (cfg.sector_count == 32'd0) ? 32'd0 : cfg.sector_count - 32'd1;

    // Output slot frees when empty or when the waiting beat is popped
    assign advance    = busy_reg && (!out_valid_reg || pop);
    assign final_beat = (job_reg.kind == JOB_STATUS) || (idx_reg == last_idx);
    assign job_take   = job_valid && (!busy_reg || (advance && final_beat));

    // Inquiry text byte and capacity word byte: most significant byte first
    always_comb
    begin
        case (idx_reg[5:3])
            3'd1:    text = cfg.vendor_text;
            3'd2:    text = cfg.product_text_upper;
            3'd3:    text = cfg.product_text_lower;
            default: text = {cfg.revision_text, 32'd0};
        endcase
        text_sh   = {3'd7 - idx_reg[2:0], 3'b000};
        text_byte = text >> text_sh;
        word      = idx_reg[2] ? 32'(SECTOR_BYTES) : last_lba;
        word_byte = word >> {2'd3 - idx_reg[1:0], 3'b000};
    end

    // Response byte for the current position
    always_comb
    begin
        data = 8'd0;
        case (job_reg.kind)
            JOB_INQUIRY:
            begin
                if (idx_reg[5:3] == 3'd0)
                begin
                    case (idx_reg[2:0])
                        3'd0:    data = INQ_DEVICE_TYPE;
                        3'd1:    data = INQ_REMOVABLE;
                        3'd3:    data = INQ_FORMAT;
                        3'd4:    data = INQ_ADD_LENGTH;
                        default: data = 8'd0;
                    endcase
                end
                else
                begin
                    data = text_byte[7:0];
                end
            end
            JOB_SENSE:
            begin
                case (idx_reg)
                    6'd0:    data = SENSE_FIXED;
                    6'd2:    data = {4'd0, job_reg.sense.key};
                    6'd7:    data = SENSE_ADD_LEN;
                    6'd12:   data = job_reg.sense.code;
                    6'd13:   data = job_reg.sense.qual;
                    default: data = 8'd0;
                endcase
            end
            JOB_CAPACITY:
            begin
                data = word_byte[7:0];
            end
            JOB_MODE:
            begin
                data = (idx_reg == 6'd0) ? MODE_DATA_LEN : 8'd0;
            end
            default:
            begin
                data = 8'd0;
            end
        endcase
    end

    // Assemble the beat
    always_comb
    begin
        beat.status       = job_reg.status;
        beat.xfer_bytes   = job_reg.tlen;
        beat.read_request = job_reg.read_request;
        beat.read_address = job_reg.read_address;
        beat.read_sectors = job_reg.read_sectors;
        beat.last         = final_beat;
        if (job_reg.kind == JOB_STATUS)
        begin
            beat.data_byte  = 8'd0;
            beat.data_valid = 1'b0;
        end
        else
        begin
            beat.data_byte  = data;
            beat.data_valid = 1'b1;
        end
    end

    // Sequencer next state
    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            idx_next       = idx_reg + 6'd1;
            out_valid_next = 1'b1;
            if (final_beat)
            begin
                busy_next = 1'b0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (job_take)
        begin
            busy_next = 1'b1;
            idx_next  = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            job_reg <= job;
        end
        if (advance)
        begin
            out_reg <= beat;
        end
    end

endmodule
